// ===== rtl/dtc_pkg.sv =====
// Shared types, constants and tables for the date/time check and BCD encode unit.
// Used by dtc_lane, dtc_merge and date_time_check_bcd_encode_unit.
package dtc_pkg;

    localparam int NUM_FIELDS = 7;

    localparam logic [2:0] POS_SEC   = 3'd0;
    localparam logic [2:0] POS_MIN   = 3'd1;
    localparam logic [2:0] POS_HOUR  = 3'd2;
    localparam logic [2:0] POS_DAY   = 3'd3;
    localparam logic [2:0] POS_MONTH = 3'd4;
    localparam logic [2:0] POS_YEAR  = 3'd5;
    localparam logic [2:0] POS_WDAY  = 3'd6;

    localparam logic [11:0] SKIP_CODE = 12'd255;
    localparam logic [11:0] YEAR_BASE = 12'd2000;
    localparam logic [2:0]  DATE_MIN_COUNT = 3'd3;

    // Reciprocal of 100 scaled by 2^19, good for any 12-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Reciprocal of 10 scaled by 2^10, good for values below 100
    localparam logic [6:0]  RECIP_10 = 7'd103;

    typedef struct packed {
        logic        used;
        logic        skip;
        logic        range_ok;
        logic [11:0] value;
        logic [7:0]  bcd;
    } t_lane_res;

    typedef struct packed {
        logic [7:0] weekday_bcd;
        logic [7:0] year_bcd;
        logic [7:0] month_bcd;
        logic [7:0] day_bcd;
        logic [7:0] hours_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] seconds_bcd;
        logic [6:0] write_mask;
        logic       setting_ok;
    } t_result;

    function automatic logic [11:0] field_lo(input logic [2:0] idx);
        case (idx)
            POS_SEC:   field_lo = 12'd0;
            POS_MIN:   field_lo = 12'd0;
            POS_HOUR:  field_lo = 12'd0;
            POS_DAY:   field_lo = 12'd1;
            POS_MONTH: field_lo = 12'd1;
            POS_YEAR:  field_lo = 12'd2000;
            POS_WDAY:  field_lo = 12'd1;
            default:   field_lo = 12'd0;
        endcase
    endfunction

    function automatic logic [11:0] field_hi(input logic [2:0] idx);
        case (idx)
            POS_SEC:   field_hi = 12'd59;
            POS_MIN:   field_hi = 12'd59;
            POS_HOUR:  field_hi = 12'd23;
            POS_DAY:   field_hi = 12'd31;
            POS_MONTH: field_hi = 12'd12;
            POS_YEAR:  field_hi = 12'd2099;
            POS_WDAY:  field_hi = 12'd6;
            default:   field_hi = 12'd0;
        endcase
    endfunction

    // Days in a month for a common year; zero for month codes out of range
    function automatic logic [4:0] month_days(input logic [3:0] m);
        case (m)
            4'd1:    month_days = 5'd31;
            4'd2:    month_days = 5'd28;
            4'd3:    month_days = 5'd31;
            4'd4:    month_days = 5'd30;
            4'd5:    month_days = 5'd31;
            4'd6:    month_days = 5'd30;
            4'd7:    month_days = 5'd31;
            4'd8:    month_days = 5'd31;
            4'd9:    month_days = 5'd30;
            4'd10:   month_days = 5'd31;
            4'd11:   month_days = 5'd30;
            4'd12:   month_days = 5'd31;
            default: month_days = 5'd0;
        endcase
    endfunction

endpackage

// ===== rtl/dtc_lane.sv =====
// One field lane: masks the field by the count, range checks it and encodes it as BCD.
// Depends on dtc_pkg for limits and the lane result type.
module dtc_lane #(
    parameter int LANE = 0
) (
    input  logic [2:0]            i_count,
    input  logic [11:0]           i_raw,
    output dtc_pkg::t_lane_res    o_res
);
    import dtc_pkg::*;

    localparam logic [2:0] LANE_IDX = 3'(LANE);

    logic        w_used;
    logic [11:0] w_value;
    logic        w_skip;
    logic [11:0] w_rel;
    logic [6:0]  w_bin;
    logic [13:0] w_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_tens_x10;
    logic [6:0]  w_units;

    assign w_used  = i_count > LANE_IDX;
    assign w_value = w_used ? i_raw : 12'd0;
    assign w_skip  = w_value == SKIP_CODE;

    // Year lane encodes the offset from the base year
    assign w_rel  = (LANE_IDX == POS_YEAR) ? (w_value - YEAR_BASE) : w_value;
    assign w_bin  = w_rel[6:0];
    assign w_prod = {7'd0, w_bin} * {7'd0, RECIP_10};
    assign w_tens = w_prod[13:10];
    assign w_tens_x10 = {w_tens[3:0], 3'b000} + {2'b00, w_tens[3:0], 1'b0};
    assign w_units    = w_bin - w_tens_x10;

    always_comb begin
        o_res.used     = w_used;
        o_res.skip     = w_skip;
        o_res.range_ok = !w_used || w_skip ||
                         ((w_value >= field_lo(LANE_IDX)) && (w_value <= field_hi(LANE_IDX)));
        o_res.value    = w_value;
        o_res.bcd      = {w_tens, w_units[3:0]};
    end

endmodule

// ===== rtl/dtc_merge.sv =====
// Merging stage: combines lane range results, applies the date consistency rule
// and builds the gated result. Depends on dtc_pkg.
module dtc_merge (
    input  logic [2:0]                          i_count,
    input  dtc_pkg::t_lane_res [6:0]            i_lanes,
    output dtc_pkg::t_result                    o_result
);
    import dtc_pkg::*;

    logic        w_range_all;
    logic        w_sd;
    logic        w_sm;
    logic        w_sy;
    logic [11:0] w_year;
    logic [11:0] w_month;
    logic [11:0] w_day;
    logic [24:0] w_yprod;
    logic [5:0]  w_q100;
    logic [11:0] w_q_x100;
    logic        w_div100;
    logic        w_leap;
    logic [4:0]  w_last;
    logic        w_month_ok;
    logic        w_fits;
    logic        w_date_ok;
    logic        w_ok;
    logic [6:0]  w_mask;

    always_comb begin
        w_range_all = 1'b1;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            w_range_all = w_range_all & i_lanes[k].range_ok;
        end
    end

    assign w_sd    = i_lanes[POS_DAY].skip;
    assign w_sm    = i_lanes[POS_MONTH].skip;
    assign w_sy    = i_lanes[POS_YEAR].skip;
    assign w_year  = i_lanes[POS_YEAR].value;
    assign w_month = i_lanes[POS_MONTH].value;
    assign w_day   = i_lanes[POS_DAY].value;

    // Gregorian leap rule: divisible by 4, and not by 100 unless by 400
    assign w_yprod  = {13'd0, w_year} * {12'd0, RECIP_100};
    assign w_q100   = w_yprod[RECIP_SHIFT +: 6];
    assign w_q_x100 = {w_q100, 6'd0} + {1'b0, w_q100, 5'd0} + {4'd0, w_q100, 2'd0};
    assign w_div100 = w_year == w_q_x100;
    assign w_leap   = (w_year[1:0] == 2'b00) && (!w_div100 || (w_q100[1:0] == 2'b00));

    assign w_month_ok = (w_month >= 12'd1) && (w_month <= 12'd12);
    always_comb begin
        w_last = month_days(w_month[3:0]);
        if (w_month == 12'd2 && w_leap) begin
            w_last = 5'd29;
        end
    end
    assign w_fits = w_month_ok && (w_day >= 12'd1) && (w_day <= {7'd0, w_last});

    always_comb begin
        w_date_ok = 1'b1;
        if (i_count > DATE_MIN_COUNT && !(w_sd && w_sm && w_sy)) begin
            w_date_ok = !(w_sd || w_sm || w_sy) && w_fits;
        end
    end

    assign w_ok = w_range_all && w_date_ok;

    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            w_mask[k] = w_ok && i_lanes[k].used && !i_lanes[k].skip;
        end
    end

    always_comb begin
        o_result.setting_ok  = w_ok;
        o_result.write_mask  = w_mask;
        o_result.seconds_bcd = w_mask[POS_SEC]   ? i_lanes[POS_SEC].bcd   : 8'd0;
        o_result.minutes_bcd = w_mask[POS_MIN]   ? i_lanes[POS_MIN].bcd   : 8'd0;
        o_result.hours_bcd   = w_mask[POS_HOUR]  ? i_lanes[POS_HOUR].bcd  : 8'd0;
        o_result.day_bcd     = w_mask[POS_DAY]   ? i_lanes[POS_DAY].bcd   : 8'd0;
        o_result.month_bcd   = w_mask[POS_MONTH] ? i_lanes[POS_MONTH].bcd : 8'd0;
        o_result.year_bcd    = w_mask[POS_YEAR]  ? i_lanes[POS_YEAR].bcd  : 8'd0;
        o_result.weekday_bcd = w_mask[POS_WDAY]  ? i_lanes[POS_WDAY].bcd  : 8'd0;
    end

endmodule

// ===== rtl/date_time_check_bcd_encode_unit.sv =====
// Date/time setting check and BCD encode unit, top level.
// Instantiates seven dtc_lane copies and dtc_merge; depends on dtc_pkg.
//
// Accepts one time setting per clock and returns one result per setting, in order.
// Seven field lanes range check and BCD encode their fields side by side, and a
// merging stage applies the day/month/year rule and builds the write mask. The
// lanes and the merge are combinational between the input port and a single
// output register, so a setting's result is presented in the cycle after its
// transfer and a new setting is taken every cycle; the output register holds
// its result under backpressure and the input stalls only while that register
// is full and not being drained.
module date_time_check_bcd_encode_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] field_count, [10:3] seconds_in, [18:11] minutes_in, [26:19] hours_in,
    // [34:27] day_in, [42:35] month_in, [54:43] year_in, [62:55] weekday_in, [63] zero
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] setting_ok, [7:1] write_mask, [15:8] seconds_bcd, [23:16] minutes_bcd,
    // [31:24] hours_bcd, [39:32] day_bcd, [47:40] month_bcd, [55:48] year_bcd,
    // [63:56] weekday_bcd
    output logic [63:0] o_m_axis_tdata
);
    import dtc_pkg::*;

    logic [2:0]         w_count;
    logic [11:0]        w_raw [NUM_FIELDS];
    t_lane_res [6:0]    w_lanes;
    t_result            w_result;
    logic               w_in_xfer;

    logic               r_valid;
    logic               n_valid;
    t_result            r_result;

    assign w_count  = i_s_axis_tdata[2:0];
    assign w_raw[0] = {4'd0, i_s_axis_tdata[10:3]};
    assign w_raw[1] = {4'd0, i_s_axis_tdata[18:11]};
    assign w_raw[2] = {4'd0, i_s_axis_tdata[26:19]};
    assign w_raw[3] = {4'd0, i_s_axis_tdata[34:27]};
    assign w_raw[4] = {4'd0, i_s_axis_tdata[42:35]};
    assign w_raw[5] = i_s_axis_tdata[54:43];
    assign w_raw[6] = {4'd0, i_s_axis_tdata[62:55]};

    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_lane
        dtc_lane #(
            .LANE (g)
        ) u_lane (
            .i_count (w_count),
            .i_raw   (w_raw[g]),
            .o_res   (w_lanes[g])
        );
    end

    dtc_merge u_merge (
        .i_count  (w_count),
        .i_lanes  (w_lanes),
        .o_result (w_result)
    );

    // Take a new transfer whenever the output register is empty or draining
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_in_xfer) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_result;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_m_axis_tvalid)
        else $error("accepted setting produced no result");

    a_reject_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[63:1] == 63'd0))
        else $error("rejected setting carries nonzero fields");

    a_mask_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[7:1] != 7'd0)) |-> o_m_axis_tdata[0])
        else $error("write mask set on rejected setting");

    a_year_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[55:52] <= 4'd9) && (o_m_axis_tdata[51:48] <= 4'd9)))
        else $error("year BCD digit out of range");

    a_sec_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[15:12] <= 4'd5) && (o_m_axis_tdata[11:8] <= 4'd9)))
        else $error("seconds BCD digit out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for date_time_check_bcd_encode_unit.
// Holds its own model of the setting check and BCD encoding, scored in order
// against the output stream; depends on dtc_pkg and the unit's RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dtc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PER_PHASE = 200;

    // Field order matches the input tdata layout, lowest bits last
    typedef struct packed {
        logic        pad;
        logic [7:0]  weekday;
        logic [11:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
        logic [2:0]  count;
    } t_setting;

    // Legal limits per field, index 0 is seconds
    localparam logic [6:0][11:0] LIM_LO = {12'd1, 12'd2000, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0};
    localparam logic [6:0][11:0] LIM_HI = {12'd6, 12'd2099, 12'd12, 12'd31, 12'd23, 12'd59, 12'd59};
    localparam logic [12:1][4:0] MDAYS = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                          5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

    class date_scoreboard;
        t_result pending_q[$];
        int n_noted;
        int n_checked;
        int n_errors;

        function new();
            n_noted = 0;
            n_checked = 0;
            n_errors = 0;
        endfunction

        static function int month_len(int m, int y);
            int len;
            len = MDAYS[m];
            if (m == 2 && ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)))
                len = 29;
            return len;
        endfunction

        function logic [7:0] to_bcd8(int v);
            return 8'(((v / 10) % 10) * 16 + v % 10);
        endfunction

        function t_result predict_result(t_setting s);
            logic [6:0][11:0] raw;
            logic [11:0] f [NUM_FIELDS];
            logic [7:0] bcd [NUM_FIELDS];
            logic [6:0] mask;
            t_result r;
            bit ok;
            bit sd, sm, sy;
            int v;
            raw = {4'h0, s.weekday, s.year, 4'h0, s.month, 4'h0, s.day,
                   4'h0, s.hours, 4'h0, s.minutes, 4'h0, s.seconds};
            ok = 1'b1;
            mask = '0;
            for (int k = 0; k < NUM_FIELDS; k++)
                f[k] = (k < int'(s.count)) ? raw[k] : 12'd0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (k < int'(s.count) && f[k] != SKIP_CODE &&
                    (f[k] < LIM_LO[k] || f[k] > LIM_HI[k]))
                    ok = 1'b0;
            end
            // day, month and year go together; then the day must fit the month
            if (ok && s.count > DATE_MIN_COUNT) begin
                sd = (f[POS_DAY] == SKIP_CODE);
                sm = (f[POS_MONTH] == SKIP_CODE);
                sy = (f[POS_YEAR] == SKIP_CODE);
                if (!(sd && sm && sy)) begin
                    if (sd || sm || sy)
                        ok = 1'b0;
                    else if (f[POS_MONTH] < 12'd1 || f[POS_MONTH] > 12'd12 ||
                             f[POS_DAY] < 12'd1 ||
                             int'(f[POS_DAY]) > month_len(int'(f[POS_MONTH]),
                                                          int'(f[POS_YEAR])))
                        ok = 1'b0;
                end
            end
            for (int k = 0; k < NUM_FIELDS; k++) begin
                bcd[k] = 8'd0;
                if (ok && k < int'(s.count) && f[k] != SKIP_CODE) begin
                    v = int'(f[k]);
                    if (k == int'(POS_YEAR))
                        v = v - int'(YEAR_BASE);
                    bcd[k] = to_bcd8(v);
                    mask[k] = 1'b1;
                end
            end
            r.setting_ok = ok;
            r.write_mask = mask;
            r.seconds_bcd = bcd[POS_SEC];
            r.minutes_bcd = bcd[POS_MIN];
            r.hours_bcd = bcd[POS_HOUR];
            r.day_bcd = bcd[POS_DAY];
            r.month_bcd = bcd[POS_MONTH];
            r.year_bcd = bcd[POS_YEAR];
            r.weekday_bcd = bcd[POS_WDAY];
            return r;
        endfunction

        function void note_setting(t_setting s);
            pending_q.push_back(predict_result(s));
            n_noted++;
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                n_errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result %h, expected none", $time, got);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            compare_field("setting_ok", {7'd0, want.setting_ok}, {7'd0, got.setting_ok});
            compare_field("write_mask", {1'b0, want.write_mask}, {1'b0, got.write_mask});
            compare_field("seconds_bcd", want.seconds_bcd, got.seconds_bcd);
            compare_field("minutes_bcd", want.minutes_bcd, got.minutes_bcd);
            compare_field("hours_bcd", want.hours_bcd, got.hours_bcd);
            compare_field("day_bcd", want.day_bcd, got.day_bcd);
            compare_field("month_bcd", want.month_bcd, got.month_bcd);
            compare_field("year_bcd", want.year_bcd, got.year_bcd);
            compare_field("weekday_bcd", want.weekday_bcd, got.weekday_bcd);
        endfunction
    endclass

    logic     i_clk;
    logic     rst_n;
    logic     s_valid;
    logic     s_tready;
    t_setting s_data;
    logic     m_valid;
    logic     m_ready;
    logic [63:0] m_data;

    int send_pct = 12;
    int recv_pct = 71;
    int hold_left = 0;
    int idle_cycles = 0;

    date_scoreboard sb = new();

    date_time_check_bcd_encode_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_setting mk(int c, int se, int mi, int ho, int da, int mo,
                                    int ye, int wd);
        t_setting s;
        s = '0;
        s.count = 3'(c);
        s.seconds = 8'(se);
        s.minutes = 8'(mi);
        s.hours = 8'(ho);
        s.day = 8'(da);
        s.month = 8'(mo);
        s.year = 12'(ye);
        s.weekday = 8'(wd);
        return s;
    endfunction

    // Mostly legal values, with skips, values just past the limits and raw noise
    function automatic logic [11:0] rand_field(int lo, int hi, int bits);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 12'($urandom_range(hi, lo));
        else if (r < 80)
            return SKIP_CODE;
        else if (r < 88)
            return 12'(hi + 1);
        else if (r < 92)
            return 12'((lo == 0) ? hi + 1 : lo - 1);
        else
            return 12'($urandom & ((1 << bits) - 1));
    endfunction

    function automatic t_setting rand_setting();
        t_setting s;
        int r;
        int pick;
        s = '0;
        r = $urandom_range(99);
        s.count = (r < 45) ? 3'd7 : (r < 60) ? 3'd6 : (r < 70) ? 3'd3 : 3'($urandom_range(7));
        s.seconds = 8'(rand_field(0, 59, 8));
        s.minutes = 8'(rand_field(0, 59, 8));
        s.hours = 8'(rand_field(0, 23, 8));
        s.day = 8'(rand_field(1, 31, 8));
        s.month = 8'(rand_field(1, 12, 8));
        s.year = rand_field(2000, 2099, 12);
        s.weekday = 8'(rand_field(1, 6, 8));
        // pull the day into the month's length most of the time
        if (s.month >= 8'd1 && s.month <= 8'd12 && s.year >= 12'd2000 && s.year <= 12'd2099 &&
            $urandom_range(99) < 60)
            s.day = 8'($urandom_range(date_scoreboard::month_len(int'(s.month),
                                                                  int'(s.year)), 1));
        r = $urandom_range(99);
        if (r < 10) begin
            s.day = 8'(SKIP_CODE);
            s.month = 8'(SKIP_CODE);
            s.year = SKIP_CODE;
        end else if (r < 15) begin
            pick = $urandom_range(2);
            if (pick == 0)
                s.day = 8'(SKIP_CODE);
            else if (pick == 1)
                s.month = 8'(SKIP_CODE);
            else
                s.year = SKIP_CODE;
        end
        return s;
    endfunction

    // Enter and leave at a falling edge; valid stays high between back-to-back items
    task automatic send_setting(input t_setting s);
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= s;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output side: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (m_valid && m_ready)
                sb.check_result(t_result'(m_data));
            if (s_valid && s_tready)
                sb.note_setting(s_data);
        end
        if ((s_valid && s_tready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;

        send_pct = 12;
        recv_pct = 71;
        // no fields in use: garbage everywhere still passes with an empty mask
        send_setting(mk(0, 255, 255, 255, 255, 255, 4095, 255));
        send_setting(mk(7, 0, 0, 0, 1, 1, 2000, 1));
        send_setting(mk(7, 59, 59, 23, 31, 12, 2099, 6));
        send_setting(mk(7, 255, 255, 255, 255, 255, 255, 255));
        // time only: date fields are not looked at
        send_setting(mk(3, 59, 59, 23, 0, 0, 0, 0));
        send_setting(mk(3, 60, 0, 0, 0, 0, 0, 0));
        send_setting(mk(2, 0, 60, 99, 0, 0, 0, 0));
        send_setting(mk(3, 0, 0, 24, 0, 0, 0, 0));
        // a count of four always rejects, as does this count-five setting with skipped fields
        send_setting(mk(4, 0, 0, 0, 15, 1, 2020, 1));
        send_setting(mk(4, 0, 0, 0, 255, 1, 2020, 1));
        send_setting(mk(5, 0, 0, 0, 255, 255, 2020, 1));
        // leap rule and month lengths
        send_setting(mk(6, 0, 0, 0, 29, 2, 2024, 0));
        send_setting(mk(6, 1, 2, 3, 29, 2, 2000, 0));
        send_setting(mk(6, 0, 0, 0, 29, 2, 2023, 0));
        send_setting(mk(6, 0, 0, 0, 28, 2, 2023, 0));
        send_setting(mk(6, 0, 0, 0, 31, 4, 2050, 0));
        send_setting(mk(6, 0, 0, 0, 30, 4, 2050, 0));
        // skip-together rule
        send_setting(mk(6, 0, 0, 0, 255, 255, 255, 0));
        send_setting(mk(6, 0, 0, 0, 255, 5, 2030, 0));
        // range edges
        send_setting(mk(7, 0, 0, 0, 1, 1, 1999, 1));
        send_setting(mk(7, 0, 0, 0, 1, 1, 2100, 1));
        send_setting(mk(7, 0, 0, 0, 0, 13, 2000, 1));
        send_setting(mk(7, 0, 0, 0, 32, 1, 2000, 7));
        send_setting(mk(7, 0, 0, 0, 1, 1, 2000, 0));
        send_setting(mk(7, 45, 255, 12, 255, 255, 255, 3));
        for (int i = 0; i < RAND_PER_PHASE; i++)
            send_setting(rand_setting());

        send_pct = 71;
        recv_pct = 12;
        for (int i = 0; i < RAND_PER_PHASE; i++)
            send_setting(rand_setting());

        // hold the output off while the input keeps offering every cycle
        send_pct = 0;
        recv_pct = 0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < RAND_PER_PHASE; i++)
            send_setting(rand_setting());
        s_valid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d settings (directed edges, leap and skip rules, random mix),",
                 sb.n_noted);
        $display("checked %0d results under three stall profiles and a long output hold-off.",
                 sb.n_checked);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
